[sv/d2ics_pkg.sv]
// ----------------------------------------------------------------------------
// d2ics_pkg
// Shared opcodes and the command and status words between the controller
// and the datapath of the two-dimensional inverse-CDF sampler.
// ----------------------------------------------------------------------------
package d2ics_pkg;

    typedef enum logic [1:0] {
        OP_WR_WEIGHT = 2'd0,
        OP_WR_X      = 2'd1,
        OP_WR_Y      = 2'd2,
        OP_SAMPLE    = 2'd3
    } opcode_t;

    typedef enum logic [0:0] {
        CFG_ROWS_USED = 1'b0,
        CFG_COLS_USED = 1'b1
    } cfg_index_t;

    localparam int CFG_BITS  = 5;
    localparam int FRAC_BITS = 16;

    // Controller to datapath
    typedef struct packed {
        logic write;     // store a table write word
        logic start;     // latch the fractions, clear the scan
        logic row_scan;  // walk the table, build marginals
        logic mult;      // form uniform_y times the row marginal
        logic col_scan;  // walk the chosen row
        logic val_read;  // read the x and y value tables
        logic out_load;  // load the result registers
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic row_done;
        logic col_done;
    } status_t;

endpackage

[sv/discrete_2d_inverse_cdf_sampler.sv]
// ----------------------------------------------------------------------------
// discrete_2d_inverse_cdf_sampler
// Two-dimensional discrete sampler by inverse transform over a loaded joint
// weight table and two value tables.
// ----------------------------------------------------------------------------
//
// Table writes (opcodes write weight, write x value, write y value) are done
// in the accept cycle and return no word; a write whose index lies beyond
// the table is dropped. A sample word returns one result word: a single
// read port on the weight RAM streams one weight a cycle, first through the
// whole table up to the chosen row to build cumulative row marginals, then
// once more through the chosen row against uniform_y times its marginal.
// The row is the first whose cumulative marginal exceeds uniform_x, the
// column the first whose running sum exceeds uniform_y times the row sum;
// a fraction beyond every bound clamps to the last index in use and raises
// fell_through. The output register lets a new word in while a result
// waits for out_ready. rows_used and cols_used must be written over the
// cfg port only while the block is idle; the block does not enforce this.
// A count of zero acts as one, and one above the table size as the size.
// Table contents are undefined until written.
//
module discrete_2d_inverse_cdf_sampler #(
    parameter int MAX_ROWS    = 16,
    parameter int MAX_COLS    = 16,
    parameter int WEIGHT_BITS = 16,
    parameter int VALUE_BITS  = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,

    // Configuration write port
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [d2ics_pkg::CFG_BITS-1:0] cfg_data,

    // Input word
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     opcode,
    input  logic [3:0]                     row_index,
    input  logic [3:0]                     col_index,
    input  logic [15:0]                    weight,
    input  logic signed [31:0]             data_value,
    input  logic [15:0]                    uniform_x,
    input  logic [15:0]                    uniform_y,

    // Result word
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [31:0]             x_out,
    output logic signed [31:0]             y_out,
    output logic [3:0]                     row_chosen,
    output logic [3:0]                     col_chosen,
    output logic                           fell_through
);

    d2ics_pkg::cmd_t    cmd;
    d2ics_pkg::status_t status;
    logic               in_is_sample;

    // Only a sample word starts a scan; writes complete in the accept cycle
    assign in_is_sample = (opcode == d2ics_pkg::OP_SAMPLE);

    d2ics_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_is_sample (in_is_sample),
        .in_ready     (in_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .cmd          (cmd)
    );

    d2ics_datapath #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .WEIGHT_BITS (WEIGHT_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .opcode       (opcode),
        .row_index    (row_index),
        .col_index    (col_index),
        .weight       (weight),
        .data_value   (data_value),
        .uniform_x    (uniform_x),
        .uniform_y    (uniform_y),
        .x_out        (x_out),
        .y_out        (y_out),
        .row_chosen   (row_chosen),
        .col_chosen   (col_chosen),
        .fell_through (fell_through)
    );

endmodule

[sv/d2ics_ram.sv]
// ----------------------------------------------------------------------------
// d2ics_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module d2ics_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/d2ics_ctrl.sv]
// ----------------------------------------------------------------------------
// d2ics_ctrl
// Sequencer for the sampler: accepts words, steps the datapath through the
// row scan, the product, the column scan and the value read, and holds the
// output valid flag.
// ----------------------------------------------------------------------------
module d2ics_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_is_sample,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  d2ics_pkg::status_t  status,
    output d2ics_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW,
        S_MUL,
        S_COL,
        S_VAL,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_is_sample)
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_ROW;
                    end
                    else
                    begin
                        cmd.write = 1'b1;
                    end
                end
            end
            S_ROW:
            begin
                cmd.row_scan = 1'b1;
                if (status.row_done)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mult   = 1'b1;
                state_next = S_COL;
            end
            S_COL:
            begin
                cmd.col_scan = 1'b1;
                if (status.col_done)
                begin
                    state_next = S_VAL;
                end
            end
            S_VAL:
            begin
                cmd.val_read = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[sv/d2ics_datapath.sv]
// ----------------------------------------------------------------------------
// d2ics_datapath
// Tables, configuration registers, scan counters, running sums, the bound
// compares and the result registers of the sampler.
// ----------------------------------------------------------------------------
module d2ics_datapath #(
    parameter int MAX_ROWS    = 16,
    parameter int MAX_COLS    = 16,
    parameter int WEIGHT_BITS = 16,
    parameter int VALUE_BITS  = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  d2ics_pkg::cmd_t                cmd,
    output d2ics_pkg::status_t             status,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [d2ics_pkg::CFG_BITS-1:0] cfg_data,
    input  logic [1:0]                     opcode,
    input  logic [3:0]                     row_index,
    input  logic [3:0]                     col_index,
    input  logic [15:0]                    weight,
    input  logic signed [31:0]             data_value,
    input  logic [15:0]                    uniform_x,
    input  logic [15:0]                    uniform_y,
    output logic signed [31:0]             x_out,
    output logic signed [31:0]             y_out,
    output logic [3:0]                     row_chosen,
    output logic [3:0]                     col_chosen,
    output logic                           fell_through
);

    localparam int FB     = d2ics_pkg::FRAC_BITS;
    localparam int RB     = $clog2(MAX_ROWS);
    localparam int CB     = $clog2(MAX_COLS);
    localparam int ADDR_W = $clog2(MAX_ROWS * MAX_COLS);
    localparam int MARG_W = WEIGHT_BITS + CB;
    localparam int SUM_W  = WEIGHT_BITS + ADDR_W;
    localparam int CMP_W  = SUM_W + FB;
    localparam int PROD_W = MARG_W + FB;

    // Configuration
    logic [d2ics_pkg::CFG_BITS-1:0] rows_used_reg;
    logic [d2ics_pkg::CFG_BITS-1:0] cols_used_reg;
    logic [31:0]                    rows_w;
    logic [31:0]                    cols_w;
    logic [RB-1:0]                  nr_m1;
    logic [CB-1:0]                  nc_m1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_used_reg <= d2ics_pkg::CFG_BITS'(16);
            cols_used_reg <= d2ics_pkg::CFG_BITS'(16);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                d2ics_pkg::CFG_ROWS_USED: rows_used_reg <= cfg_data;
                d2ics_pkg::CFG_COLS_USED: cols_used_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Last index in use: a count of zero acts as one, too big a count as the table size
    assign rows_w = 32'(rows_used_reg);
    assign cols_w = 32'(cols_used_reg);

    always_comb
    begin
        if (rows_w == 32'd0)
        begin
            nr_m1 = '0;
        end
        else if (rows_w > 32'(MAX_ROWS))
        begin
            nr_m1 = RB'(MAX_ROWS - 1);
        end
        else
        begin
            nr_m1 = RB'(rows_w - 32'd1);
        end
        if (cols_w == 32'd0)
        begin
            nc_m1 = '0;
        end
        else if (cols_w > 32'(MAX_COLS))
        begin
            nc_m1 = CB'(MAX_COLS - 1);
        end
        else
        begin
            nc_m1 = CB'(cols_w - 32'd1);
        end
    end

    // Table writes: drop any index beyond the table
    logic row_ok;
    logic col_ok;
    logic wt_we;
    logic x_we;
    logic y_we;
    logic [ADDR_W-1:0] wt_waddr;

    assign row_ok   = 32'(row_index) < 32'(MAX_ROWS);
    assign col_ok   = 32'(col_index) < 32'(MAX_COLS);
    assign wt_we    = cmd.write && (opcode == d2ics_pkg::OP_WR_WEIGHT) && row_ok && col_ok;
    assign x_we     = cmd.write && (opcode == d2ics_pkg::OP_WR_X) && row_ok;
    assign y_we     = cmd.write && (opcode == d2ics_pkg::OP_WR_Y) && col_ok;
    assign wt_waddr = ADDR_W'(32'(row_index) * MAX_COLS + 32'(col_index));

    // Scan issue
    logic [RB-1:0] ri_reg;
    logic [CB-1:0] cj_reg;
    logic          iss_end_reg;
    logic          issue;
    logic          last_c;
    logic          last_r;
    logic [RB-1:0] scan_row;
    logic [ADDR_W-1:0] wt_raddr;
    logic [RB-1:0] row_reg;
    logic [CB-1:0] col_reg;

    assign issue    = (cmd.row_scan || cmd.col_scan) && !iss_end_reg;
    assign last_c   = (cj_reg == nc_m1);
    assign last_r   = (ri_reg == nr_m1);
    assign scan_row = cmd.col_scan ? row_reg : ri_reg;
    assign wt_raddr = ADDR_W'(ADDR_W'(scan_row) * ADDR_W'(MAX_COLS) + ADDR_W'(cj_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_end_reg <= 1'b0;
        end
        else if (cmd.start || cmd.mult)
        begin
            iss_end_reg <= 1'b0;
        end
        else if (issue)
        begin
            iss_end_reg <= last_c && (cmd.col_scan || last_r);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start || cmd.mult)
        begin
            ri_reg <= '0;
            cj_reg <= '0;
        end
        else if (issue)
        begin
            if (last_c)
            begin
                cj_reg <= '0;
                ri_reg <= ri_reg + RB'(1);
            end
            else
            begin
                cj_reg <= cj_reg + CB'(1);
            end
        end
    end

    // Tag of the word coming back from the weight RAM
    logic          rd_vld_reg;
    logic          rd_lastc_reg;
    logic          rd_lastr_reg;
    logic [RB-1:0] rd_row_reg;
    logic [CB-1:0] rd_col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_lastc_reg <= last_c;
        rd_lastr_reg <= last_r;
        rd_row_reg   <= ri_reg;
        rd_col_reg   <= cj_reg;
    end

    // Memories
    logic [WEIGHT_BITS-1:0] wt_rd;
    logic [VALUE_BITS-1:0]  x_rd;
    logic [VALUE_BITS-1:0]  y_rd;

    d2ics_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (MAX_ROWS * MAX_COLS)
    ) u_weight_ram (
        .clk   (clk),
        .we    (wt_we),
        .waddr (wt_waddr),
        .wdata (WEIGHT_BITS'(weight)),
        .re    (issue),
        .raddr (wt_raddr),
        .rdata (wt_rd)
    );

    d2ics_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_ROWS)
    ) u_x_ram (
        .clk   (clk),
        .we    (x_we),
        .waddr (RB'(row_index)),
        .wdata (VALUE_BITS'($unsigned(data_value))),
        .re    (cmd.val_read),
        .raddr (row_reg),
        .rdata (x_rd)
    );

    d2ics_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_COLS)
    ) u_y_ram (
        .clk   (clk),
        .we    (y_we),
        .waddr (CB'(col_index)),
        .wdata (VALUE_BITS'($unsigned(data_value))),
        .re    (cmd.val_read),
        .raddr (col_reg),
        .rdata (y_rd)
    );

    // Running sums and bound checks
    logic [FB-1:0]     ux_reg;
    logic [FB-1:0]     uy_reg;
    logic [SUM_W-1:0]  cum_reg;
    logic [MARG_W-1:0] m_reg;
    logic [MARG_W-1:0] marg_reg;
    logic [MARG_W-1:0] s_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              fell_reg;

    logic [SUM_W-1:0]  cum_n;
    logic [MARG_W-1:0] m_n;
    logic [MARG_W-1:0] s_n;
    logic [CMP_W-1:0]  ux_shift;
    logic              hit_r;
    logic              hit_c;
    logic              row_step;
    logic              col_step;

    assign cum_n    = cum_reg + SUM_W'(wt_rd);
    assign m_n      = m_reg + MARG_W'(wt_rd);
    assign s_n      = s_reg + MARG_W'(wt_rd);
    assign ux_shift = CMP_W'(ux_reg) << WEIGHT_BITS;
    assign hit_r    = ux_shift < {cum_n, {FB{1'b0}}};
    assign hit_c    = {s_n, {FB{1'b0}}} > prod_reg;
    assign row_step = cmd.row_scan && rd_vld_reg;
    assign col_step = cmd.col_scan && rd_vld_reg;

    assign status.row_done = row_step && rd_lastc_reg && (hit_r || rd_lastr_reg);
    assign status.col_done = col_step && (hit_c || rd_lastc_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            ux_reg   <= uniform_x;
            uy_reg   <= uniform_y;
            cum_reg  <= '0;
            m_reg    <= '0;
            fell_reg <= 1'b0;
        end
        else if (row_step)
        begin
            cum_reg <= cum_n;
            if (rd_lastc_reg)
            begin
                // Row end: hold the marginal if this row wins, clamp on the last one
                m_reg <= '0;
                if (hit_r || rd_lastr_reg)
                begin
                    row_reg  <= rd_row_reg;
                    marg_reg <= m_n;
                    fell_reg <= !hit_r;
                end
            end
            else
            begin
                m_reg <= m_n;
            end
        end
        else if (cmd.mult)
        begin
            prod_reg <= PROD_W'(uy_reg) * PROD_W'(marg_reg);
            s_reg    <= '0;
        end
        else if (col_step)
        begin
            s_reg <= s_n;
            if (hit_c || rd_lastc_reg)
            begin
                col_reg  <= rd_col_reg;
                fell_reg <= fell_reg || !hit_c;
            end
        end
    end

    // Result registers
    logic signed [31:0] x_out_reg;
    logic signed [31:0] y_out_reg;
    logic [3:0]         row_out_reg;
    logic [3:0]         col_out_reg;
    logic               fell_out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            x_out_reg    <= 32'(x_rd);
            y_out_reg    <= 32'(y_rd);
            row_out_reg  <= 4'(row_reg);
            col_out_reg  <= 4'(col_reg);
            fell_out_reg <= fell_reg;
        end
    end

    assign x_out        = x_out_reg;
    assign y_out        = y_out_reg;
    assign row_chosen   = row_out_reg;
    assign col_chosen   = col_out_reg;
    assign fell_through = fell_out_reg;

endmodule
